>>> rtl/core/dlfs_pkg.sv
`default_nettype none
package dlfs_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_SET_LEVEL  = 2'd1,
    CMD_SCREEN_ON  = 2'd2,
    CMD_SCREEN_OFF = 2'd3
  } cmd_t;

  // Decoded operations passed from front to back
  typedef enum logic [2:0] {
    OP_TICK,
    OP_SET_LEVEL,
    OP_SCREEN_ON,
    OP_SCREEN_OFF,
    OP_HOLD
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [3:0]  level;
  } op_t;

  // Configuration register map
  localparam logic REG_GAP_BITS = 1'b0;
  localparam logic [15:0] GAP_BITS_RESET = 16'd240;

  // Frame bytes
  localparam logic [7:0] MODE_ON_BYTE   = 8'h45;
  localparam logic [7:0] MODE_OFF_BYTE  = 8'h46;
  localparam logic [7:0] NO_CHANGE_BYTE = 8'h40;
  localparam logic [7:0] TRAILER_BYTE   = 8'h83;

  localparam logic [3:0] LEVEL_RESET = 4'd5;
  localparam logic [3:0] LAST_PHASE  = 4'd8;
  localparam logic [1:0] LAST_BYTE   = 2'd2;

  // Brightness level to line code
  function automatic logic [7:0] level_code(input logic [3:0] lvl);
    logic [7:0] code;
    case (lvl)
      4'd0:    code = 8'h20;
      4'd1:    code = 8'h61;
      4'd2:    code = 8'h62;
      4'd3:    code = 8'h23;
      4'd4:    code = 8'h64;
      4'd5:    code = 8'h25;
      4'd6:    code = 8'h26;
      4'd7:    code = 8'h67;
      4'd8:    code = 8'h68;
      4'd9:    code = 8'h29;
      4'd10:   code = 8'h2A;
      4'd11:   code = 8'h2C;
      4'd12:   code = 8'h6B;
      4'd13:   code = 8'h6D;
      4'd14:   code = 8'h6E;
      default: code = 8'h2F;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/dlfs_if.sv
`default_nettype none
// Input word channel: command and brightness level
interface dlfs_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [3:0] level;

  modport source (output valid, output cmd, output level, input ready);
  modport sink   (input valid, input cmd, input level, output ready);
endinterface

// Result word channel: line level and frame status
interface dlfs_result_if;
  logic       valid;
  logic       ready;
  logic       tx_line;
  logic       busy_res;
  logic [1:0] frame_position;

  modport source (output valid, output tx_line, output busy_res, output frame_position,
                  input ready);
  modport sink   (input valid, input tx_line, input busy_res, input frame_position,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/core/display_link_frame_serializer.sv
`default_nettype none
// Display link frame serializer.
// Repeats a three-byte frame (mode, brightness or no-change, trailer) on an
// inverted serial line, one bit time per tick word on the item channel.
// Item channel: cmd selects a bit tick, a brightness set (levels 1 to 15,
// zero is ignored), screen on or screen off. Every item yields exactly one
// result word: the line level, a busy flag and the frame byte position.
// Commands take no bit time; their result shows the level held on the line.
// Each item passes the decode register, then the queue, then the result
// register, which holds the result word.
// Throughput: one item per cycle while the receiver takes results; the back
// end executes one queued word per cycle and the result register refills in
// the cycle it is taken.
// When the receiver stalls, the result register holds, the queue fills and
// the item channel drops ready once the queue and the decode register are full.
// gap_bits (APB address 0) sets the idle bit times after each byte; write it
// only while no words are in flight.
// Reset (synchronous, active high) empties the pipeline, restores gap_bits to
// 240, screen on, brightness 5 pending, and the first byte starts on the
// first tick.
module display_link_frame_serializer import dlfs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  dlfs_item_if.sink        item,
  dlfs_result_if.source    result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  op_t         fr_op;
  logic        fr_valid;
  logic        fr_ready;
  op_t         q_op;
  logic        q_valid;
  logic        q_ready;
  logic [15:0] gap_bits;
  logic        reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_GAP_BITS) && (paddr[1:0] == 2'd0);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_bits <= GAP_BITS_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      gap_bits <= pwdata[15:0];
    end
  end

  assign prdata = reg_hit ? {16'd0, gap_bits} : 32'd0;

  dlfs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .op       (fr_op),
    .op_valid (fr_valid),
    .op_ready (fr_ready)
  );

  dlfs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_op    (fr_op),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .pop_op     (q_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  dlfs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (q_op),
    .op_valid (q_valid),
    .op_ready (q_ready),
    .gap_bits (gap_bits),
    .result   (result)
  );

endmodule
`default_nettype wire

>>> rtl/core/dlfs_front.sv
`default_nettype none
module dlfs_front import dlfs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  dlfs_item_if.sink    item,
  output op_t          op,
  output logic         op_valid,
  input  wire logic    op_ready
);

  op_t  op_reg;
  logic op_valid_reg;
  op_t  decoded;

  // Classify the incoming word; a set-level command with a level of zero leaves state alone
  always_comb begin
    decoded.level = item.level;
    case (cmd_t'(item.cmd))
      CMD_TICK:       decoded.kind = OP_TICK;
      CMD_SET_LEVEL:  decoded.kind = (item.level != 4'd0) ? OP_SET_LEVEL : OP_HOLD;
      CMD_SCREEN_ON:  decoded.kind = OP_SCREEN_ON;
      CMD_SCREEN_OFF: decoded.kind = OP_SCREEN_OFF;
      default:        decoded.kind = OP_HOLD;
    endcase
  end

  assign item.ready = !op_valid_reg || op_ready;

  // Hold the decoded word until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid_reg <= 1'b0;
    end else if (item.ready) begin
      op_valid_reg <= item.valid;
    end
    if (item.ready && item.valid) begin
      op_reg <= decoded;
    end
  end

  assign op       = op_reg;
  assign op_valid = op_valid_reg;

endmodule
`default_nettype wire

>>> rtl/core/dlfs_queue.sv
`default_nettype none
module dlfs_queue import dlfs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire op_t  push_op,
  input  wire logic push_valid,
  output logic      push_ready,
  output op_t       pop_op,
  output logic      pop_valid,
  input  wire logic pop_ready
);

  op_t        entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_op     = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/dlfs_back.sv
`default_nettype none
module dlfs_back import dlfs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire op_t         op,
  input  wire logic        op_valid,
  output logic             op_ready,
  input  wire logic [15:0] gap_bits,
  dlfs_result_if.source    result
);

  // Transmitter state
  logic        screen_on;
  logic [3:0]  brightness_level;
  logic        brightness_pending;
  logic [1:0]  byte_index;
  logic [7:0]  shift_byte;
  logic [3:0]  bit_phase;
  logic [15:0] gap_counter;

  logic        screen_on_next;
  logic [3:0]  brightness_level_next;
  logic        brightness_pending_next;
  logic [1:0]  byte_index_next;
  logic [7:0]  shift_byte_next;
  logic [3:0]  bit_phase_next;
  logic [15:0] gap_counter_next;

  // Output register
  logic        out_valid;
  logic        tx_line;
  logic        busy_res;
  logic [1:0]  frame_position;
  logic        line_next;
  logic        busy_next;

  logic        step;
  logic [7:0]  frame_byte;
  logic [3:0]  tick_bit;
  logic [3:0]  hold_bit;

  assign op_ready = !out_valid || result.ready;
  assign step     = op_valid && op_ready;
  assign tick_bit = bit_phase - 4'd1;
  assign hold_bit = bit_phase - 4'd2;

  // Pick the next frame byte
  always_comb begin
    case (byte_index)
      2'd1:    frame_byte = brightness_pending ? level_code(brightness_level)
                                               : NO_CHANGE_BYTE;
      2'd2:    frame_byte = TRAILER_BYTE;
      default: frame_byte = screen_on ? MODE_ON_BYTE : MODE_OFF_BYTE;
    endcase
  end

  // Execute one word
  always_comb begin
    screen_on_next          = screen_on;
    brightness_level_next   = brightness_level;
    brightness_pending_next = brightness_pending;
    byte_index_next         = byte_index;
    shift_byte_next         = shift_byte;
    bit_phase_next          = bit_phase;
    gap_counter_next        = gap_counter;
    line_next               = 1'b0;
    busy_next               = 1'b0;
    case (op.kind)
      OP_TICK: begin
        if (bit_phase == 4'd0) begin
          if (gap_counter != 16'd0) begin
            gap_counter_next = gap_counter - 16'd1;
          end else begin
            shift_byte_next = frame_byte;
            bit_phase_next  = 4'd1;
            line_next       = 1'b1;
            busy_next       = 1'b1;
            if (byte_index == 2'd1) brightness_pending_next = 1'b0;
          end
        end else begin
          line_next = !shift_byte[tick_bit[2:0]];
          busy_next = 1'b1;
          if (bit_phase == LAST_PHASE) begin
            bit_phase_next   = 4'd0;
            gap_counter_next = gap_bits;
            byte_index_next  = (byte_index == LAST_BYTE) ? 2'd0 : byte_index + 2'd1;
          end else begin
            bit_phase_next = bit_phase + 4'd1;
          end
        end
      end
      default: begin
        case (op.kind)
          OP_SET_LEVEL: begin
            brightness_level_next   = op.level;
            brightness_pending_next = 1'b1;
          end
          OP_SCREEN_ON:  screen_on_next = 1'b1;
          OP_SCREEN_OFF: screen_on_next = 1'b0;
          default: ;
        endcase
        // Show the level left on the line by the last tick
        if (bit_phase == 4'd1) begin
          line_next = 1'b1;
          busy_next = 1'b1;
        end else if (bit_phase != 4'd0) begin
          line_next = !shift_byte[hold_bit[2:0]];
          busy_next = 1'b1;
        end
      end
    endcase
  end

  // Commit state and load the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_on          <= 1'b1;
      brightness_level   <= LEVEL_RESET;
      brightness_pending <= 1'b1;
      byte_index         <= 2'd0;
      shift_byte         <= 8'd0;
      bit_phase          <= 4'd0;
      gap_counter        <= 16'd0;
      out_valid          <= 1'b0;
    end else begin
      if (step) begin
        screen_on          <= screen_on_next;
        brightness_level   <= brightness_level_next;
        brightness_pending <= brightness_pending_next;
        byte_index         <= byte_index_next;
        shift_byte         <= shift_byte_next;
        bit_phase          <= bit_phase_next;
        gap_counter        <= gap_counter_next;
      end
      if (op_ready) out_valid <= op_valid;
    end
    if (step) begin
      tx_line        <= line_next;
      busy_res       <= busy_next;
      frame_position <= byte_index;
    end
  end

  assign result.valid          = out_valid;
  assign result.tx_line        = tx_line;
  assign result.busy_res       = busy_res;
  assign result.frame_position = frame_position;

endmodule
`default_nettype wire

>>> tb/tb_display_link_frame_serializer.sv
module tb_display_link_frame_serializer;
  import dlfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PARK_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned REPORT_CAP     = 20;
  localparam logic [2:0]  GAP_ADDR       = {REG_GAP_BITS, 2'b00};

  // Brightness level to line code
  localparam logic [7:0] BRIGHT_CODE [16] = '{
    8'h20, 8'h61, 8'h62, 8'h23, 8'h64, 8'h25, 8'h26, 8'h67,
    8'h68, 8'h29, 8'h2A, 8'h2C, 8'h6B, 8'h6D, 8'h6E, 8'h2F
  };

  typedef struct {
    cmd_t       cmd;
    logic [3:0] level;
  } link_word_t;

  typedef struct {
    logic       tx_line;
    logic       busy;
    logic [1:0] pos;
  } line_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dlfs_item_if   item_ch();
  dlfs_result_if result_ch();

  display_link_frame_serializer u_dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch.sink),
    .result  (result_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Serializer state mirror
  logic        screen_on;
  logic [3:0]  bright_level;
  logic        bright_pending;
  logic [1:0]  byte_idx;
  logic [7:0]  shift_reg;
  logic [3:0]  phase;
  logic [15:0] gap_left;
  logic [15:0] gap_cfg;

  link_word_t  word_queue[$];
  line_word_t  line_queue[$];
  link_word_t  cur_word;

  int unsigned mismatches = 0;
  int unsigned tx_wait;
  int unsigned rx_wait;
  int unsigned idle_cycles = 0;
  bit          steady_tx = 1'b0;
  bit          steady_rx = 1'b0;
  bit          park_rx = 1'b0;
  bit          rx_parked;

  // Known levels on the channels before the first edge
  initial begin
    item_ch.valid   = 1'b0;
    item_ch.cmd     = CMD_TICK;
    item_ch.level   = 4'd0;
    result_ch.ready = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the serializer by one word and return the line it shows
  function automatic line_word_t step_line(cmd_t cmd, logic [3:0] level);
    line_word_t w;
    logic [2:0] bit_sel;
    w.tx_line = 1'b0;
    w.busy    = 1'b0;
    w.pos     = byte_idx;
    if (cmd == CMD_TICK) begin
      if (phase == 4'd0) begin
        if (gap_left != 16'd0) begin
          gap_left = gap_left - 16'd1;
        end else begin
          case (byte_idx)
            2'd1: begin
              if (bright_pending) begin
                shift_reg = BRIGHT_CODE[bright_level];
                bright_pending = 1'b0;
              end else begin
                shift_reg = NO_CHANGE_BYTE;
              end
            end
            2'd2: shift_reg = TRAILER_BYTE;
            default: shift_reg = screen_on ? MODE_ON_BYTE : MODE_OFF_BYTE;
          endcase
          phase = 4'd1;
          w.tx_line = 1'b1;
          w.busy = 1'b1;
        end
      end else begin
        bit_sel = 3'(phase - 4'd1);
        w.tx_line = ~shift_reg[bit_sel];
        w.busy = 1'b1;
        if (phase == 4'd8) begin
          phase = 4'd0;
          gap_left = gap_cfg;
          byte_idx = (byte_idx == 2'd2) ? 2'd0 : byte_idx + 2'd1;
        end else begin
          phase = phase + 4'd1;
        end
      end
    end else begin
      case (cmd)
        CMD_SET_LEVEL: begin
          if (level != 4'd0) begin
            bright_level = level;
            bright_pending = 1'b1;
          end
        end
        CMD_SCREEN_ON: screen_on = 1'b1;
        default:       screen_on = 1'b0;
      endcase
      // Hold the level of the last bit on the line
      if (phase == 4'd1) begin
        w.tx_line = 1'b1;
        w.busy = 1'b1;
      end else if (phase >= 4'd2) begin
        bit_sel = 3'(phase - 4'd2);
        w.tx_line = ~shift_reg[bit_sel];
        w.busy = 1'b1;
      end
    end
    return w;
  endfunction

  // Draw a gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly ticks so frames keep turning, commands sprinkled in
  function automatic link_word_t random_word();
    link_word_t  w;
    int unsigned r;
    r = $urandom_range(0, 99);
    w.level = 4'($urandom_range(0, 15));
    if (r < 78) w.cmd = CMD_TICK;
    else if (r < 90) w.cmd = CMD_SET_LEVEL;
    else if (r < 95) w.cmd = CMD_SCREEN_ON;
    else w.cmd = CMD_SCREEN_OFF;
    return w;
  endfunction

  // Driver: predict on accept, then offer the next word after its gap
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      tx_wait <= 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        line_queue.push_back(step_line(cur_word.cmd, cur_word.level));
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (tx_wait != 0) begin
          tx_wait <= tx_wait - 1;
          item_ch.valid <= 1'b0;
        end else if (word_queue.size() != 0) begin
          cur_word = word_queue.pop_front();
          item_ch.valid <= 1'b1;
          item_ch.cmd <= cur_word.cmd;
          item_ch.level <= cur_word.level;
          tx_wait <= pick_gap(steady_tx);
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word against the oldest expectation
  always @(posedge clk) begin
    line_word_t exp_w;
    if (rst) begin
      result_ch.ready <= 1'b0;
      rx_wait <= 0;
      rx_parked <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (line_queue.size() == 0) begin
          if (mismatches < REPORT_CAP)
            $display("%0t: result word with none expected: line %0b busy %0b pos %0d",
                     $realtime, result_ch.tx_line, result_ch.busy_res,
                     result_ch.frame_position);
          mismatches++;
        end else begin
          exp_w = line_queue.pop_front();
          if (result_ch.tx_line !== exp_w.tx_line || result_ch.busy_res !== exp_w.busy ||
              result_ch.frame_position !== exp_w.pos) begin
            if (mismatches < REPORT_CAP)
              $display("%0t: expected line %0b busy %0b pos %0d, got line %0b busy %0b pos %0d",
                       $realtime, exp_w.tx_line, exp_w.busy, exp_w.pos,
                       result_ch.tx_line, result_ch.busy_res, result_ch.frame_position);
            mismatches++;
          end
        end
      end
      // Stall the receiver: one long hold-off on request, else random gaps
      if (park_rx && !rx_parked) begin
        rx_parked <= 1'b1;
        rx_wait <= PARK_CYCLES;
        result_ch.ready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        result_ch.ready <= 1'b0;
      end else begin
        rx_wait <= pick_gap(steady_rx);
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles without any handshake
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (word_queue.size() != 0 || item_ch.valid || line_queue.size() != 0);
  endtask

  task automatic write_gap(input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= GAP_ADDR;
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    gap_cfg = value;
  endtask

  // Drain, set the gap, then queue a batch of random words
  task automatic run_phase(input logic [15:0] gap, input int unsigned count, input bit park);
    wait_drained();
    repeat (3) @(posedge clk);
    write_gap(gap);
    @(negedge clk);
    steady_tx = park || ($urandom_range(0, 3) == 0);
    steady_rx = ($urandom_range(0, 3) == 0);
    repeat (count) word_queue.push_back(random_word());
    if (park) park_rx = 1'b1;
  endtask

  task automatic push_word(input cmd_t cmd, input logic [3:0] level);
    link_word_t w;
    w.cmd = cmd;
    w.level = level;
    word_queue.push_back(w);
  endtask

  initial begin
    screen_on = 1'b1;
    bright_level = LEVEL_RESET;
    bright_pending = 1'b1;
    byte_idx = 2'd0;
    shift_reg = 8'd0;
    phase = 4'd0;
    gap_left = 16'd0;
    gap_cfg = GAP_BITS_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: first byte at the reset gap, commands mid-byte and in the gap
    push_word(CMD_TICK, 4'd0);
    push_word(CMD_SET_LEVEL, 4'd0);
    push_word(CMD_TICK, 4'd15);
    push_word(CMD_TICK, 4'd0);
    push_word(CMD_SCREEN_OFF, 4'd0);
    repeat (4) push_word(CMD_TICK, 4'd0);
    push_word(CMD_SET_LEVEL, 4'd15);
    repeat (3) push_word(CMD_TICK, 4'd15);
    push_word(CMD_SCREEN_ON, 4'd0);
    push_word(CMD_SET_LEVEL, 4'd1);
    push_word(CMD_TICK, 4'd0);
    push_word(CMD_TICK, 4'd0);
    push_word(CMD_SCREEN_OFF, 4'd15);
    push_word(CMD_SCREEN_ON, 4'd0);
    push_word(CMD_SET_LEVEL, 4'd0);
    push_word(CMD_TICK, 4'd0);

    // Random: zero and minimum gap, a run of short gaps, the longest gap last
    run_phase(16'd0, 150, 1'b0);
    run_phase(16'd1, 150, 1'b0);
    for (int p = 0; p < 8; p++)
      run_phase(16'($urandom_range(0, 12)), 200, p == 3);
    run_phase(16'hFFFF, 60, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && line_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> display_link_frame_serializer.f
rtl/core/dlfs_pkg.sv
rtl/core/dlfs_if.sv
rtl/core/dlfs_front.sv
rtl/core/dlfs_queue.sv
rtl/core/dlfs_back.sv
rtl/core/display_link_frame_serializer.sv
tb/tb_display_link_frame_serializer.sv
